// File: rtl/base64_decode_stream_assert.svh
// Assertion macros shared by the base64 decoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BASE64_DECODE_STREAM_ASSERT_SVH
`define BASE64_DECODE_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
`define B64D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define B64D_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define B64D_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define B64D_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 decoder.
// No dependencies; used by the result interface and all decoder modules.
package b64d_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int LEN_BITS       = 24;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ENC = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_valid;
    logic       end_of_text;
  } item_t;

  // Everything one input item hands to the result stage.
  typedef struct packed {
    logic                load;
    logic [1:0]          nbytes;
    logic [23:0]         word;
    logic                has_status;
    logic [1:0]          status;
    logic [LEN_BITS-1:0] length;
  } bundle_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c + 8'h04);
    end else if (c == CHAR_PLUS) begin
      r.val = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/b64d_if.sv
// Valid/ready channel interfaces for characters in and results out.
// Depends on b64d_pkg for the length width.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       char_valid;
  logic       end_of_text;

  modport source (output valid, in_char, char_valid, end_of_text, input ready);
  modport sink   (input valid, in_char, char_valid, end_of_text, output ready);
endinterface

interface b64d_result_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic                          is_status;
  logic [1:0]                    status;
  logic [b64d_pkg::LEN_BITS-1:0] decoded_length;
  logic                          last;

  modport source (output valid, out_byte, is_status, status, decoded_length, last,
                  input ready);
  modport sink   (input valid, out_byte, is_status, status, decoded_length, last,
                  output ready);
endinterface

// File: rtl/b64d_core.sv
// Input register, group state and decode logic of the base64 decoder.
// Depends on b64d_pkg, b64d_if and the assertion macro header.
`include "base64_decode_stream_assert.svh"

module b64d_core #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  b64d_char_if.sink          chars,
  input  logic               bundle_free,
  output b64d_pkg::bundle_t  bundle
);

  b64d_pkg::item_t item;
  logic            item_v;
  logic            load;

  logic [17:0]           acc;
  logic [1:0]            char_pos;
  logic                  third_was_pad;
  logic                  bad_flag;
  logic                  finished;
  logic [COUNT_BITS-1:0] byte_count;

  logic [17:0]           acc_next;
  logic [1:0]            char_pos_next;
  logic                  third_was_pad_next;
  logic                  bad_flag_next;
  logic                  finished_next;
  logic [COUNT_BITS-1:0] byte_count_next;

  logic [17:0]           acc_c;
  logic [1:0]            pos_c;
  logic                  third_c;
  logic                  bad_c;
  logic                  fin_c;
  logic [COUNT_BITS-1:0] cnt_c;
  logic [1:0]            nb;
  logic [23:0]           word;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [b64d_pkg::LEN_BITS-1:0] len_sat;

  b64d_pkg::sextet_t sx;
  logic              pad;

  assign load        = item_v && bundle_free;
  assign chars.ready = !item_v || bundle_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (chars.ready) begin
      item_v <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item.in_char     <= chars.in_char;
      item.char_valid  <= chars.char_valid;
      item.end_of_text <= chars.end_of_text;
    end
  end

  assign sx      = b64d_pkg::sextet_of(item.in_char);
  assign pad     = (item.in_char == b64d_pkg::CHAR_PAD);
  assign cnt_sum = {1'b0, byte_count} + {{(COUNT_BITS - 1){1'b0}}, nb};

  // State after the character, before the end marker is applied.
  always_comb begin
    acc_c   = acc;
    pos_c   = char_pos;
    third_c = third_was_pad;
    bad_c   = bad_flag;
    fin_c   = finished;
    cnt_c   = byte_count;
    nb      = 2'd0;
    word    = 24'd0;
    if (item.char_valid) begin
      if (!bad_flag && !finished) begin
        case (char_pos)
          2'd0: begin
            if (!sx.ok) begin
              bad_c = 1'b1;
            end else begin
              acc_c = {sx.val, 12'd0};
            end
            third_c = 1'b0;
          end
          2'd1: begin
            if (!sx.ok) begin
              bad_c = 1'b1;
            end else begin
              acc_c = acc | {6'd0, sx.val, 6'd0};
            end
          end
          2'd2: begin
            if (pad) begin
              third_c = 1'b1;
            end else if (!sx.ok) begin
              bad_c = 1'b1;
            end else begin
              acc_c = acc | {12'd0, sx.val};
            end
          end
          default: begin
            if (third_was_pad) begin
              if (!pad) begin
                bad_c = 1'b1;
              end else begin
                nb = 2'd1;
              end
            end else if (pad) begin
              nb = 2'd2;
            end else if (!sx.ok) begin
              bad_c = 1'b1;
            end else begin
              nb = 2'd3;
            end
            word = {acc, (nb == 2'd3) ? sx.val : 6'd0};
            if (nb != 2'd0) begin
              cnt_c = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
              fin_c = (nb != 2'd3);
            end
            third_c = 1'b0;
          end
        endcase
      end
      pos_c = char_pos + 2'd1;
    end
  end

  generate
    if (COUNT_BITS > b64d_pkg::LEN_BITS) begin : g_len_wide
      assign len_sat = (|cnt_c[COUNT_BITS-1:b64d_pkg::LEN_BITS]) ? '1
                                                                 : cnt_c[b64d_pkg::LEN_BITS-1:0];
    end else if (COUNT_BITS == b64d_pkg::LEN_BITS) begin : g_len_same
      assign len_sat = cnt_c;
    end else begin : g_len_narrow
      assign len_sat = {{(b64d_pkg::LEN_BITS - COUNT_BITS){1'b0}}, cnt_c};
    end
  endgenerate

  // Build the bundle; on the end marker, add the status result and return to the reset state.
  always_comb begin
    acc_next           = acc_c;
    char_pos_next      = pos_c;
    third_was_pad_next = third_c;
    bad_flag_next      = bad_c;
    finished_next      = fin_c;
    byte_count_next    = cnt_c;
    bundle.load        = load;
    bundle.nbytes      = nb;
    bundle.word        = word;
    bundle.has_status  = item.end_of_text;
    bundle.status      = b64d_pkg::ST_OK;
    bundle.length      = '0;
    if (item.end_of_text) begin
      if (pos_c != 2'd0) begin
        bundle.status = b64d_pkg::ST_BAD_LEN;
      end else if (bad_c) begin
        bundle.status = b64d_pkg::ST_BAD_ENC;
      end else begin
        bundle.length = len_sat;
      end
      acc_next           = '0;
      char_pos_next      = 2'd0;
      third_was_pad_next = 1'b0;
      bad_flag_next      = 1'b0;
      finished_next      = 1'b0;
      byte_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      char_pos      <= 2'd0;
      third_was_pad <= 1'b0;
      bad_flag      <= 1'b0;
      finished      <= 1'b0;
      byte_count    <= '0;
    end else if (load) begin
      acc           <= acc_next;
      char_pos      <= char_pos_next;
      third_was_pad <= third_was_pad_next;
      bad_flag      <= bad_flag_next;
      finished      <= finished_next;
      byte_count    <= byte_count_next;
    end
  end

  `B64D_ASSERT_IMP(a_bytes_on_fourth, clk, rst, load && (nb != 2'd0), char_pos == 2'd3 && item.char_valid && !bad_flag && !finished, "bytes decoded outside the fourth place of a group")
  `B64D_ASSERT_NXT(a_eot_clears, clk, rst, load && item.end_of_text, char_pos == 2'd0 && !bad_flag && !finished && byte_count == '0, "state not cleared after end marker")
  `B64D_ASSERT_IMP(a_no_bytes_after_pad, clk, rst, finished || bad_flag, nb == 2'd0, "bytes decoded after padding or error")

endmodule

// File: rtl/b64d_out.sv
// Result register and serializer: delivers a decoded bundle one result a cycle while the receiver is ready.
// Depends on b64d_pkg, b64d_if and the assertion macro header.
`include "base64_decode_stream_assert.svh"

module b64d_out (
  input  logic              clk,
  input  logic              rst,
  input  b64d_pkg::bundle_t bundle,
  output logic              bundle_free,
  b64d_result_if.source     results
);

  logic [1:0]                    byte_left;
  logic                          stat_pend;
  logic [23:0]                   word;
  logic [1:0]                    status;
  logic [b64d_pkg::LEN_BITS-1:0] length;
  logic                          fire;
  logic                          show_status;

  assign show_status = (byte_left == 2'd0) && stat_pend;

  assign results.valid          = (byte_left != 2'd0) || stat_pend;
  assign results.out_byte       = (byte_left != 2'd0) ? word[23:16] : 8'd0;
  assign results.is_status      = show_status;
  assign results.status         = show_status ? status : b64d_pkg::ST_OK;
  assign results.decoded_length = show_status ? length : '0;
  assign results.last           = ((byte_left == 2'd1) && !stat_pend) || show_status;

  assign fire        = results.valid && results.ready;
  assign bundle_free = !results.valid || (results.ready && results.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_left <= 2'd0;
      stat_pend <= 1'b0;
    end else if (bundle.load) begin
      byte_left <= bundle.nbytes;
      stat_pend <= bundle.has_status;
    end else if (fire) begin
      if (byte_left != 2'd0) begin
        byte_left <= byte_left - 2'd1;
      end else begin
        stat_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) begin
      word   <= bundle.word;
      status <= bundle.status;
      length <= bundle.length;
    end else if (fire) begin
      word <= {word[15:0], 8'd0};
    end
  end

  `B64D_ASSERT_IMP(a_load_when_free, clk, rst, bundle.load, !results.valid || (results.ready && results.last), "bundle loaded over undelivered results")
  `B64D_ASSERT_NXT(a_rest_follows, clk, rst, fire && !results.last, results.valid, "results of one item lost")
  `B64D_ASSERT_IMP(a_status_last, clk, rst, results.valid && results.is_status, results.last, "status result not last")

endmodule

// File: rtl/base64_decode_stream.sv
// Streaming base64 decoder (standard alphabet, '=' padding), top level.
// A request waits in the core's input register while it is decoded; its bundle
// is registered into the result stage once that is free. Throughput: one request
// per cycle while each request yields at most one result and results are taken;
// a request with more results holds the single-result output port until taken.
// Reset: synchronous, active high; clears the group state and both stages.
module base64_decode_stream #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  b64d_char_if.sink     chars,
  b64d_result_if.source results
);

  // The core holds each request in its input register, classifies the
  // character against the base64 alphabet and updates the group state:
  // the accumulated sextets, the place in the group, the third-place pad
  // flag, the sticky error, the end-of-decoding flag after a padded group,
  // and the saturating byte count. Its output is one bundle per request:
  // up to three bytes and, on the end marker, one status result.
  b64d_pkg::bundle_t bundle;

  // The result stage holds the bundle and hands it out one result per cycle while ready.
  // The core may pass it a new bundle in the same cycle that the last result
  // of the old one is taken, so requests flow without bubbles.
  logic bundle_free;

  b64d_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .bundle_free (bundle_free),
    .bundle      (bundle)
  );

  b64d_out u_out (
    .clk         (clk),
    .rst         (rst),
    .bundle      (bundle),
    .bundle_free (bundle_free),
    .results     (results)
  );

endmodule

// File: tb/sv/base64_decode_check.sv
`timescale 1ns / 100ps
// Watches both channels of base64_decode_stream, predicts every result from the
// accepted requests and compares them in order. Depends on b64d_pkg and b64d_if.
module base64_decode_check (
  input  logic   clk,
  input  logic   rst,
  b64d_char_if   chars,
  b64d_result_if results,
  output int     errors,
  output int     pending
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                is_status;
    logic [1:0]          status;
    logic [LEN_BITS-1:0] decoded_length;
    logic                last;
  } result_t;

  localparam logic [LEN_BITS-1:0] COUNT_MAX   = '1;
  localparam int                  PRINT_LIMIT = 40;

  result_t expected_results[$];
  int      result_index;

  // Decoder state as seen from outside.
  logic [17:0]         group_bits;
  logic [1:0]          group_pos;
  logic                third_pad;
  logic                enc_bad;
  logic                pad_seen;
  logic [LEN_BITS-1:0] byte_total;

  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                result_index, name, got, want));
    end
  endtask

  task automatic clear_text_state();
    group_bits = '0;
    group_pos  = '0;
    third_pad  = 1'b0;
    enc_bad    = 1'b0;
    pad_seen   = 1'b0;
    byte_total = '0;
  endtask

  // Six-bit value of a character, or -1 outside the alphabet.
  function automatic int char_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == CHAR_PLUS) return 62;
    if (c == CHAR_SLASH) return 63;
    return -1;
  endfunction

  task automatic decode_request(logic [7:0] c, logic cv, logic eot);
    result_t     r [4];
    int          n;
    int          v;
    int          nb;
    logic        is_pad;
    logic [23:0] word;
    n = 0;
    if (cv) begin
      if (!enc_bad && !pad_seen) begin
        v      = char_value(c);
        is_pad = (c == CHAR_PAD);
        case (group_pos)
          2'd0: begin
            if (v < 0) enc_bad = 1'b1;
            else group_bits = 18'(v) << 12;
            third_pad = 1'b0;
          end
          2'd1: begin
            if (v < 0) enc_bad = 1'b1;
            else group_bits = group_bits | (18'(v) << 6);
          end
          2'd2: begin
            if (is_pad) third_pad = 1'b1;
            else if (v < 0) enc_bad = 1'b1;
            else group_bits = group_bits | 18'(v);
          end
          default: begin
            if (third_pad) begin
              if (!is_pad) enc_bad = 1'b1;
              nb = 1;
              v  = 0;
            end else if (is_pad) begin
              nb = 2;
              v  = 0;
            end else if (v < 0) begin
              enc_bad = 1'b1;
              nb      = 0;
              v       = 0;
            end else begin
              nb = 3;
            end
            if (!enc_bad) begin
              word = {group_bits, 6'(v)};
              for (int i = 0; i < nb; i++) begin
                r[n]          = '0;
                r[n].out_byte = word[23 - 8 * i -: 8];
                n++;
              end
              byte_total = (COUNT_MAX - byte_total < nb) ? COUNT_MAX
                                                         : byte_total + LEN_BITS'(nb);
              if (nb < 3) pad_seen = 1'b1;
            end
            third_pad = 1'b0;
          end
        endcase
      end
      group_pos = group_pos + 2'd1;
    end
    if (eot) begin
      r[n]           = '0;
      r[n].is_status = 1'b1;
      if (group_pos != 2'd0) r[n].status = ST_BAD_LEN;
      else if (enc_bad) r[n].status = ST_BAD_ENC;
      else r[n].status = ST_OK;
      if (r[n].status == ST_OK) r[n].decoded_length = byte_total;
      n++;
      clear_text_state();
    end
    if (n > 0) r[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_text_state();
      expected_results.delete();
      errors       = 0;
      result_index = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_index));
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", 24'(results.out_byte), 24'(want.out_byte));
          check_field("is_status", 24'(results.is_status), 24'(want.is_status));
          check_field("status", 24'(results.status), 24'(want.status));
          check_field("decoded_length", 24'(results.decoded_length),
                      24'(want.decoded_length));
          check_field("last", 24'(results.last), 24'(want.last));
        end
        result_index++;
      end
      if (chars.valid && chars.ready) begin
        decode_request(chars.in_char, chars.char_valid, chars.end_of_text);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/sv/base64_decode_stream_test.sv
`timescale 1ns / 100ps
// Top of the base64_decode_stream testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on b64d_pkg, b64d_if and
// base64_decode_check.
module base64_decode_stream_test;
  import b64d_pkg::*;

  localparam int IDLE_PCT       = 17;
  localparam int RANDOM_ITEMS   = 320;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  // Where the end marker of a text goes.
  typedef enum {END_NONE, END_ON_CHAR, END_ALONE} end_mode_e;

  logic clk;
  logic rst;
  int   fails;
  int   pending;

  // Written only by the stimulus process. While steady is set neither side idles
  // at random; each increment of holds_asked asks the receiver for one long stall.
  bit   steady;
  int   holds_asked;

  b64d_char_if   chars ();
  b64d_result_if results ();

  base64_decode_stream dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  base64_decode_check u_check (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results),
    .errors  (fails),
    .pending (pending)
  );

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side. Ready drops at random, except inside the steady stretch, and
  // for a long stall whenever the stimulus asks for one. The stall is counted
  // here, so the sender keeps offering requests until the decoder backs up.
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run if neither channel moves for too long. The slowest correct
  // stretch is one long receiver stall plus the decoder latency, far below
  // the limit.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((chars.valid && chars.ready) || (results.valid && results.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] alphabet_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid is
  // left high so that a following request goes out back to back; it drops
  // only during an idle gap, with junk on the payload meanwhile.
  task automatic send_request(logic [7:0] c, logic cv, logic eot);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      chars.valid       <= 1'b0;
      chars.in_char     <= 8'($urandom);
      chars.char_valid  <= 1'($urandom);
      chars.end_of_text <= 1'($urandom);
      @(posedge clk);
    end
    chars.valid       <= 1'b1;
    chars.in_char     <= c;
    chars.char_valid  <= cv;
    chars.end_of_text <= eot;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
  endtask

  // Sends a text one character per request and returns the request count.
  task automatic send_text(logic [7:0] text [$], end_mode_e mode, output int sent);
    int len;
    len = text.size();
    for (int i = 0; i < len; i++) begin
      send_request(text[i], 1'b1, (mode == END_ON_CHAR) && (i == len - 1));
    end
    if (mode == END_ALONE) send_request(8'h00, 1'b0, 1'b1);
    sent = len + ((mode == END_ALONE) ? 1 : 0);
  endtask

  task automatic send_string(string s, end_mode_e mode);
    logic [7:0] text [$];
    int         sent;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text, mode, sent);
  endtask

  // Builds one random text. Most are well formed, with random content and
  // random padding, so that the decoder really emits bytes; the rest carry a
  // noise byte, a stray pad, a missing character or trailing characters.
  task automatic send_random_text(int max_groups, output int sent);
    logic [7:0] text [$];
    int         groups;
    int         pads;
    int         kind;
    int         idx;
    end_mode_e  mode;
    if (max_groups > 0) groups = max_groups;
    else if ($urandom_range(9) == 0) groups = $urandom_range(12, 6);
    else groups = $urandom_range(3);
    for (int i = 0; i < 4 * groups; i++) text.push_back(alphabet_char($urandom_range(63)));
    if (groups > 0) begin
      pads = $urandom_range(2);
      for (int i = 0; i < pads; i++) text[text.size() - 1 - i] = CHAR_PAD;
    end
    kind = (max_groups > 0) ? 0 : $urandom_range(99);
    if (kind >= 75 && text.size() == 0) begin
      text.push_back(8'($urandom));
    end else if (kind >= 92) begin
      repeat ($urandom_range(3, 1)) text.push_back(alphabet_char($urandom_range(63)));
    end else if (kind >= 87) begin
      text.delete($urandom_range(text.size() - 1));
    end else if (kind >= 82) begin
      text[$urandom_range(text.size() - 1)] = CHAR_PAD;
    end else if (kind >= 75) begin
      idx       = $urandom_range(text.size() - 1);
      text[idx] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
    end
    // A request with neither a character nor the end mark changes nothing;
    // it does not count toward the request total.
    if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
    mode = (text.size() == 0 || $urandom_range(1) == 0) ? END_ALONE : END_ON_CHAR;
    send_text(text, mode, sent);
  endtask

  initial begin
    int sent;
    int total;
    rst               <= 1'b1;
    chars.valid       <= 1'b0;
    chars.in_char     <= 8'h00;
    chars.char_valid  <= 1'b0;
    chars.end_of_text <= 1'b0;
    steady      = 1'b0;
    holds_asked = 0;
    total       = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts. A full group with the end mark on its last character
    // yields three bytes and the status from one request.
    send_string("TWFu", END_ON_CHAR);
    // One pad in the fourth place, with both symbol characters, and a status
    // request of its own.
    send_string("+/z=", END_ALONE);
    // A double pad ends decoding; later characters only count toward the
    // length, which is then not a multiple of four.
    send_string("AA==Zg", END_ON_CHAR);
    // Pad in the second place is bad encoding.
    send_string("A=AA", END_ON_CHAR);
    // Pad in the third place followed by a real character is bad encoding.
    send_string("AB=C", END_ON_CHAR);
    // A character code above the alphabet, and a pad in the first place; both
    // also leave the length three short of a group, which is reported first.
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(CHAR_PAD, 1'b1, 1'b1);
    // A request with no character and no end mark, then an empty text.
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);

    // Back-pressure: the receiver stalls for a long stretch while a long
    // well-formed text goes out without gaps, so the decoder fills up and
    // holds off its input.
    steady = 1'b1;
    holds_asked++;
    send_random_text(10, sent);
    total += sent;
    steady = 1'b0;

    // Random texts, with one stretch in which neither side idles.
    while (total < RANDOM_ITEMS) begin
      steady = (total >= 150 && total < 210);
      send_random_text(0, sent);
      total += sent;
    end
    steady = 1'b0;
    chars.valid <= 1'b0;

    // Let the last request reach the checker, wait for every expected result,
    // then give the decoder time to show anything it should not send.
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_core.sv
rtl/b64d_out.sv
rtl/base64_decode_stream.sv
tb/sv/base64_decode_check.sv
tb/sv/base64_decode_stream_test.sv
